FILE: rtl/ipv4rxc_pkg.sv
// ----------------------------------------------------------------------------
// ipv4rxc_pkg
// Shared types and constants for the IPv4 receive classifier.
// ----------------------------------------------------------------------------
package ipv4rxc_pkg;

   // Verdict codes carried in the result
   typedef enum logic [2:0] {
      VERDICT_MALFORMED  = 3'd0,
      VERDICT_NO_HANDLER = 3'd1,
      VERDICT_ECHO_REQ   = 3'd2,
      VERDICT_ECHO_REP   = 3'd3,
      VERDICT_DHCP       = 3'd4,
      VERDICT_DNS        = 3'd5,
      VERDICT_TCP        = 3'd6
   } verdict_type;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_IFACE_UP   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCAL_ADDR = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PING_IDENT = 2'd2;

   localparam logic [15:0] PING_IDENT_RESET = 16'h1234;

   // Header byte offsets
   localparam logic [15:0] OFS_VER_HLEN  = 16'd0;
   localparam logic [15:0] OFS_TOTAL_HI  = 16'd2;
   localparam logic [15:0] OFS_TOTAL_LO  = 16'd3;
   localparam logic [15:0] OFS_PROTOCOL  = 16'd9;
   localparam logic [15:0] OFS_SRC_FIRST = 16'd12;
   localparam logic [15:0] OFS_SRC_LAST  = 16'd15;
   localparam logic [15:0] OFS_DST_FIRST = 16'd16;
   localparam logic [15:0] OFS_DST_LAST  = 16'd19;

   // Layer-4 offsets relative to the end of the IPv4 header
   localparam logic [15:0] L4_OFS_TYPE    = 16'd0;
   localparam logic [15:0] L4_OFS_W2_HI   = 16'd2;
   localparam logic [15:0] L4_OFS_W2_LO   = 16'd3;
   localparam logic [15:0] L4_OFS_W4_HI   = 16'd4;
   localparam logic [15:0] L4_OFS_W4_LO   = 16'd5;

   localparam logic [15:0] MIN_HDR_LEN    = 16'd20;
   localparam logic [15:0] L4_HDR_LEN     = 16'd8;
   localparam logic [3:0]  IP_VERSION_4   = 4'd4;
   localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

   localparam logic [7:0]  PROTO_ICMP     = 8'd1;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [7:0]  ICMP_ECHO_REQ  = 8'd8;
   localparam logic [7:0]  ICMP_ECHO_REP  = 8'd0;
   localparam logic [15:0] PORT_DHCP      = 16'd68;
   localparam logic [15:0] PORT_DNS       = 16'd53;
   localparam logic [15:0] PORT_DNS_ALT   = 16'd1053;

   localparam int unsigned RSP_DATA_W     = 72;

   // One received byte
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } beat_type;

   // Configuration registers
   typedef struct packed {
      logic        iface_up;
      logic [31:0] local_addr;
      logic [15:0] ping_ident;
   } csr_type;

   // One result
   typedef struct packed {
      verdict_type verdict;
      logic [31:0] source_addr;
      logic [15:0] payload_length;
      logic [15:0] udp_data_length;
   } rsp_type;

endpackage

FILE: rtl/ipv4rxc_in_reg.sv
// ----------------------------------------------------------------------------
// ipv4rxc_in_reg
// Input register for received bytes; holds a final byte while the result
// register is still occupied.
// ----------------------------------------------------------------------------
module ipv4rxc_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] data_byte
   input  logic                 req_tlast,
   input  logic                 out_free,
   output logic                 fire,
   output ipv4rxc_pkg::beat_type beat
);

   logic                  valid_ff, valid_in;
   ipv4rxc_pkg::beat_type beat_ff, beat_in;
   logic                  accept;

   // Byte moves on unless it is a final byte facing a full result register
   assign fire       = valid_ff && (!beat_ff.last_byte || out_free);
   assign req_tready = !valid_ff || fire;
   assign accept     = req_tvalid && req_tready;
   assign beat       = beat_ff;

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (accept) begin
         valid_in            = 1'b1;
         beat_in.data_byte   = req_tdata;
         beat_in.last_byte   = req_tlast;
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

endmodule

FILE: rtl/ipv4rxc_parser.sv
// ----------------------------------------------------------------------------
// ipv4rxc_parser
// Byte counter and header field capture; computes the verdict for the
// packet when its final byte passes.
// ----------------------------------------------------------------------------
module ipv4rxc_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  ipv4rxc_pkg::beat_type beat,
   input  ipv4rxc_pkg::csr_type  csr,
   output ipv4rxc_pkg::rsp_type  result
);

   logic [15:0] offset_ff, offset_in, count;
   logic [7:0]  vh_ff, vh_in, vh_cap;
   logic [15:0] tl_ff, tl_in, tl_cap;
   logic [7:0]  proto_ff, proto_in, proto_cap;
   logic [31:0] src_ff, src_in, src_cap;
   logic [31:0] dst_ff, dst_in, dst_cap;
   logic [7:0]  l4b0_ff, l4b0_in, l4b0_cap;
   logic [15:0] l4w2_ff, l4w2_in, l4w2_cap;
   logic [15:0] l4w4_ff, l4w4_in, l4w4_cap;

   logic [15:0] old_hlen, l4_rel;
   logic        l4_on;
   logic [15:0] hlen, plen;
   logic        malformed;

   // Received count, saturating
   assign count = (offset_ff == ipv4rxc_pkg::COUNT_MAX) ? ipv4rxc_pkg::COUNT_MAX
                                                        : offset_ff + 16'd1;

   // Header length as it stood before this byte
   assign old_hlen = {10'd0, vh_ff[3:0], 2'b00};
   assign l4_rel   = offset_ff - old_hlen;
   assign l4_on    = (old_hlen >= ipv4rxc_pkg::MIN_HDR_LEN) && (offset_ff >= old_hlen);

   // Field capture for the byte at the current offset
   always_comb begin
      vh_cap    = vh_ff;
      tl_cap    = tl_ff;
      proto_cap = proto_ff;
      src_cap   = src_ff;
      dst_cap   = dst_ff;
      l4b0_cap  = l4b0_ff;
      l4w2_cap  = l4w2_ff;
      l4w4_cap  = l4w4_ff;
      if (offset_ff == ipv4rxc_pkg::OFS_VER_HLEN) begin
         vh_cap = beat.data_byte;
      end else if (offset_ff == ipv4rxc_pkg::OFS_TOTAL_HI) begin
         tl_cap = {beat.data_byte, tl_ff[7:0]};
      end else if (offset_ff == ipv4rxc_pkg::OFS_TOTAL_LO) begin
         tl_cap = {tl_ff[15:8], beat.data_byte};
      end else if (offset_ff == ipv4rxc_pkg::OFS_PROTOCOL) begin
         proto_cap = beat.data_byte;
      end else if (offset_ff >= ipv4rxc_pkg::OFS_SRC_FIRST &&
                   offset_ff <= ipv4rxc_pkg::OFS_SRC_LAST) begin
         src_cap = {src_ff[23:0], beat.data_byte};
      end else if (offset_ff >= ipv4rxc_pkg::OFS_DST_FIRST &&
                   offset_ff <= ipv4rxc_pkg::OFS_DST_LAST) begin
         dst_cap = {dst_ff[23:0], beat.data_byte};
      end
      if (l4_on) begin
         if (l4_rel == ipv4rxc_pkg::L4_OFS_TYPE) begin
            l4b0_cap = beat.data_byte;
         end else if (l4_rel == ipv4rxc_pkg::L4_OFS_W2_HI) begin
            l4w2_cap = {beat.data_byte, l4w2_ff[7:0]};
         end else if (l4_rel == ipv4rxc_pkg::L4_OFS_W2_LO) begin
            l4w2_cap = {l4w2_ff[15:8], beat.data_byte};
         end else if (l4_rel == ipv4rxc_pkg::L4_OFS_W4_HI) begin
            l4w4_cap = {beat.data_byte, l4w4_ff[7:0]};
         end else if (l4_rel == ipv4rxc_pkg::L4_OFS_W4_LO) begin
            l4w4_cap = {l4w4_ff[15:8], beat.data_byte};
         end
      end
   end

   // Verdict from the fields including the current byte
   assign hlen = {10'd0, vh_cap[3:0], 2'b00};
   assign plen = tl_cap - hlen;
   assign malformed = (count < ipv4rxc_pkg::MIN_HDR_LEN) ||
                      (vh_cap[7:4] != ipv4rxc_pkg::IP_VERSION_4) ||
                      (hlen < ipv4rxc_pkg::MIN_HDR_LEN) ||
                      (tl_cap > count) || (tl_cap < hlen);

   always_comb begin
      result = '0;
      result.verdict = ipv4rxc_pkg::VERDICT_MALFORMED;
      if (!malformed) begin
         result.verdict        = ipv4rxc_pkg::VERDICT_NO_HANDLER;
         result.source_addr    = src_cap;
         result.payload_length = plen;
         if (proto_cap == ipv4rxc_pkg::PROTO_ICMP) begin
            if (plen >= ipv4rxc_pkg::L4_HDR_LEN) begin
               if (l4b0_cap == ipv4rxc_pkg::ICMP_ECHO_REQ && csr.iface_up &&
                   dst_cap == csr.local_addr) begin
                  result.verdict = ipv4rxc_pkg::VERDICT_ECHO_REQ;
               end else if (l4b0_cap == ipv4rxc_pkg::ICMP_ECHO_REP &&
                            l4w4_cap == csr.ping_ident) begin
                  result.verdict = ipv4rxc_pkg::VERDICT_ECHO_REP;
               end
            end
         end else if (proto_cap == ipv4rxc_pkg::PROTO_UDP) begin
            if (plen >= ipv4rxc_pkg::L4_HDR_LEN) begin
               if (l4w4_cap >= ipv4rxc_pkg::L4_HDR_LEN) begin
                  result.udp_data_length = l4w4_cap - ipv4rxc_pkg::L4_HDR_LEN;
               end
               if (l4w2_cap == ipv4rxc_pkg::PORT_DHCP) begin
                  result.verdict = ipv4rxc_pkg::VERDICT_DHCP;
               end else if (l4w2_cap == ipv4rxc_pkg::PORT_DNS_ALT ||
                            l4w2_cap == ipv4rxc_pkg::PORT_DNS) begin
                  result.verdict = ipv4rxc_pkg::VERDICT_DNS;
               end
            end
         end else if (proto_cap == ipv4rxc_pkg::PROTO_TCP) begin
            result.verdict = ipv4rxc_pkg::VERDICT_TCP;
         end
      end
   end

   // State update: capture on each byte, clear after the final byte
   always_comb begin
      offset_in = offset_ff;
      vh_in     = vh_ff;
      tl_in     = tl_ff;
      proto_in  = proto_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      l4b0_in   = l4b0_ff;
      l4w2_in   = l4w2_ff;
      l4w4_in   = l4w4_ff;
      if (fire) begin
         if (beat.last_byte) begin
            offset_in = '0;
            vh_in     = '0;
            tl_in     = '0;
            proto_in  = '0;
            src_in    = '0;
            dst_in    = '0;
            l4b0_in   = '0;
            l4w2_in   = '0;
            l4w4_in   = '0;
         end else begin
            offset_in = count;
            vh_in     = vh_cap;
            tl_in     = tl_cap;
            proto_in  = proto_cap;
            src_in    = src_cap;
            dst_in    = dst_cap;
            l4b0_in   = l4b0_cap;
            l4w2_in   = l4w2_cap;
            l4w4_in   = l4w4_cap;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         vh_ff     <= '0;
         tl_ff     <= '0;
         proto_ff  <= '0;
         src_ff    <= '0;
         dst_ff    <= '0;
         l4b0_ff   <= '0;
         l4w2_ff   <= '0;
         l4w4_ff   <= '0;
      end else begin
         offset_ff <= offset_in;
         vh_ff     <= vh_in;
         tl_ff     <= tl_in;
         proto_ff  <= proto_in;
         src_ff    <= src_in;
         dst_ff    <= dst_in;
         l4b0_ff   <= l4b0_in;
         l4w2_ff   <= l4w2_in;
         l4w4_ff   <= l4w4_in;
      end
   end

endmodule

FILE: rtl/ipv4rxc_out_reg.sv
// ----------------------------------------------------------------------------
// ipv4rxc_out_reg
// Result register driving the response stream.
// ----------------------------------------------------------------------------
module ipv4rxc_out_reg (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  ipv4rxc_pkg::rsp_type                 result,
   output logic                                 out_free,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ipv4rxc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   logic                 valid_ff, valid_in;
   ipv4rxc_pkg::rsp_type data_ff, data_in;

   assign out_free   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   // Packed low to high: verdict, source_addr, payload_length, udp_data_length
   assign rsp_tdata  = {5'd0, data_ff.udp_data_length, data_ff.payload_length,
                        data_ff.source_addr, data_ff.verdict};

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

FILE: rtl/ipv4_rx_classifier.sv
// ----------------------------------------------------------------------------
// ipv4_rx_classifier
// Classifies received IPv4 packets streamed one byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one packet byte per transfer, starting at the IPv4 header;
//            req_tlast marks the final byte of the packet.
//   rsp_*  : one verdict transfer per packet, issued for the final byte.
//   csr_*  : register writes (iface_up, local_addr, ping_ident), taken at
//            any edge with csr_we high; write them only while idle.
// Throughput: one byte per cycle, except while a final byte waits on a held
//   result, through an input register and a result register with one level
//   of field capture and compare logic.
// Result path: the final byte enters the input register at its transfer edge;
//   the verdict enters the result register when that byte passes on.
// Reset: clears the byte counter and captured fields, empties both
//   registers, and sets iface_up = 0, local_addr = 0, ping_ident = 0x1234.
// Stall: a held result blocks the next final byte, and the input behind it;
//   earlier bytes keep flowing and are absorbed into the captured header state.
// ----------------------------------------------------------------------------
module ipv4_rx_classifier (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [7:0]                              req_tdata,   // [7:0] data_byte
   input  logic                                    req_tlast,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // [2:0] verdict, [34:3] source_addr, [50:35] payload_length,
   // [66:51] udp_data_length, [71:67] zero
   output logic [ipv4rxc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                    csr_we,
   input  logic [ipv4rxc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ipv4rxc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   ipv4rxc_pkg::csr_type  csr_ff, csr_in;
   ipv4rxc_pkg::beat_type beat;
   ipv4rxc_pkg::rsp_type  result;
   logic                  fire;
   logic                  out_free;

   // Configuration registers
   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         unique case (csr_index)
            ipv4rxc_pkg::CSR_IFACE_UP:   csr_in.iface_up   = csr_wdata[0];
            ipv4rxc_pkg::CSR_LOCAL_ADDR: csr_in.local_addr = csr_wdata;
            ipv4rxc_pkg::CSR_PING_IDENT: csr_in.ping_ident = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.iface_up   <= 1'b0;
         csr_ff.local_addr <= '0;
         csr_ff.ping_ident <= ipv4rxc_pkg::PING_IDENT_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   ipv4rxc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .out_free   (out_free),
      .fire       (fire),
      .beat       (beat)
   );

   ipv4rxc_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .beat   (beat),
      .csr    (csr_ff),
      .result (result)
   );

   ipv4rxc_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (fire && beat.last_byte),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef NO_ASSERTIONS
   // A final byte that passes always produces a result next cycle
   a_final_gives_result: assert property (@(posedge clock) disable iff (reset)
      fire && beat.last_byte |=> rsp_tvalid)
      else $error("final byte did not produce a result");

   // A final byte never passes into an occupied, stalled result register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !(fire && beat.last_byte))
      else $error("result overwritten while stalled");

   // Verdict code seven is never produced
   a_verdict_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] != 3'd7)
      else $error("verdict out of range");

   // Malformed packets carry all-zero fields
   a_malformed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == ipv4rxc_pkg::VERDICT_MALFORMED
      |-> rsp_tdata[66:3] == '0)
      else $error("malformed result carries nonzero fields");
`endif

endmodule
